// ===== src/bbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int CH_W      = 8;
	localparam int POS_W     = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int MIN_SIZE  = 3;

	localparam int IMAGE_WIDTH_RST  = 640;
	localparam int IMAGE_HEIGHT_RST = 480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// floor(x / 9) = (x * 7282) >> 16 for x up to 9 * 255
	localparam int RS_W     = CH_W + 2;
	localparam int SUM_W    = CH_W + 4;
	localparam int DIV9_MUL = 7282;
	localparam int DIV9_SH  = 16;
	localparam int PROD_W   = SUM_W + 13;

	// result slots of one input word, in emission order
	localparam int RES_MAIN = 0;
	localparam int RES_EOL  = 1;
	localparam int RES_EOF  = 2;
	localparam int RES_N    = 3;

	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = 3;

	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [2:0][CH_W-1:0] rgb_t;

	typedef struct packed {
		logic             frame_start;
		logic [CH_W-1:0]  red_in;
		logic [CH_W-1:0]  green_in;
		logic [CH_W-1:0]  blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic [CH_W-1:0]  red_out;
		logic [CH_W-1:0]  green_out;
		logic [CH_W-1:0]  blue_out;
		logic             last_of_run;
	} pix_out_t;

	typedef struct packed {
		logic             interior;
		logic [RES_N-1:0] has;
		logic [POS_W-1:0] r1_row;
		logic [POS_W-1:0] r1_col;
		logic [POS_W-1:0] r2_col;
		logic [POS_W-1:0] r3_row;
		logic [POS_W-1:0] r3_col;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		rgb_t  rgb;
	} q_entry_t;

endpackage

// ===== src/bbr_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_line_store
// Two line stores packed in one memory word per column: {row j-1, row j-2}.
// Read at accept, write back in the next cycle, with forwarding of that write
// to a read of the same column. Cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module bbr_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_idx,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_idx,
	input  bbr_pkg::rgb_t       wr_px,
	output bbr_pkg::rgb_t       col_a,
	output bbr_pkg::rgb_t       col_b,
	output logic                busy
);

	localparam int PW = $bits(bbr_pkg::rgb_t);

	logic [2*PW-1:0] mem [DEPTH];
	logic [2*PW-1:0] rd_q;
	logic [2*PW-1:0] fwd_data_q;
	logic [2*PW-1:0] cur;
	logic [2*PW-1:0] wr_word;
	logic            fwd_q;
	logic            busy_q;
	logic [AW-1:0]   clr_q;

	assign cur     = fwd_q ? fwd_data_q : rd_q;
	assign col_a   = cur[2*PW-1:PW];
	assign col_b   = cur[PW-1:0];
	assign wr_word = {wr_px, col_a};
	assign busy    = busy_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
		fwd_data_q <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= 1'b0;
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else begin
			if (rd_en) begin
				fwd_q <= wr_en && (wr_idx == rd_idx);
			end
			if (busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(DEPTH - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (wr_idx == rd_idx) |=> fwd_q)
		else $error("forwarding flag not set for same-column access");
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !wr_en && !rd_en)
		else $error("line store accessed during clearing sweep");
	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(clr_q) == AW'(DEPTH - 1))
		else $error("clearing sweep ended early");
`endif

endmodule

// ===== src/bbr_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_window
// 3x3 window registers, row sums, total and divide by nine.
// Fixed pipeline s1 -> s4, no stalls; s4 pushes into the result queue.
// ----------------------------------------------------------------------------
module bbr_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  bbr_pkg::meta_t     s1_meta,
	input  bbr_pkg::rgb_t      col_top,
	input  bbr_pkg::rgb_t      col_mid,
	input  bbr_pkg::rgb_t      col_bot,
	output logic               push,
	output bbr_pkg::q_entry_t  push_entry
);

	bbr_pkg::rgb_t  win_q [3][3];

	logic           valid_s2, valid_s3, valid_s4;
	bbr_pkg::meta_t meta_s2, meta_s3, meta_s4;

	logic [bbr_pkg::RS_W-1:0]   rs_d  [3][3];
	logic [bbr_pkg::RS_W-1:0]   rs_s3 [3][3];
	logic [bbr_pkg::SUM_W-1:0]  tot_d [3];
	logic [bbr_pkg::PROD_W-1:0] prod_d  [3];
	logic [bbr_pkg::PROD_W-1:0] prod_s4 [3];
	bbr_pkg::rgb_t              avg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (s1_valid) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_top;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= col_bot;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int ch = 0; ch < 3; ch++) begin
				rs_d[r][ch] = bbr_pkg::RS_W'(win_q[r][0][ch])
					+ bbr_pkg::RS_W'(win_q[r][1][ch])
					+ bbr_pkg::RS_W'(win_q[r][2][ch]);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot_d[ch] = bbr_pkg::SUM_W'(rs_s3[0][ch]) + bbr_pkg::SUM_W'(rs_s3[1][ch])
				+ bbr_pkg::SUM_W'(rs_s3[2][ch]);
			prod_d[ch] = bbr_pkg::PROD_W'(tot_d[ch])
				* bbr_pkg::PROD_W'(bbr_pkg::DIV9_MUL);
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			avg[ch] = prod_s4[ch][bbr_pkg::DIV9_SH +: bbr_pkg::CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= s1_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		meta_s2 <= s1_meta;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
		rs_s3   <= rs_d;
		prod_s4 <= prod_d;
	end

	assign push            = valid_s4 && (meta_s4.has != '0);
	assign push_entry.meta = meta_s4;
	assign push_entry.rgb  = meta_s4.interior ? avg : '0;

endmodule

// ===== src/bbr_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_out_queue
// Queue of per-pixel entries; each entry is sent as one to three result
// words, one word per accepted handshake.
// ----------------------------------------------------------------------------
module bbr_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bbr_pkg::q_entry_t  push_entry,
	output logic               blur_valid,
	input  logic               blur_ready,
	output bbr_pkg::pix_out_t  blur,
	output logic               pop
);

	bbr_pkg::q_entry_t          q_mem [bbr_pkg::Q_DEPTH];
	logic [bbr_pkg::Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [bbr_pkg::Q_AW:0]     count_q;
	logic [bbr_pkg::RES_N-1:0]  done_q;

	bbr_pkg::q_entry_t          head;
	logic [bbr_pkg::RES_N-1:0]  rem, cur;
	logic                       last, word_acc;

	assign head       = q_mem[rd_ptr_q];
	assign rem        = head.meta.has & ~done_q;
	assign cur        = rem & (~rem + 1'b1);
	assign last       = (rem == cur);
	assign blur_valid = (count_q != '0);
	assign word_acc   = blur_valid && blur_ready;
	assign pop        = word_acc && last;

	always_comb begin
		blur.last_of_run = last;
		if (cur[bbr_pkg::RES_MAIN]) begin
			blur.out_row   = head.meta.r1_row;
			blur.out_col   = head.meta.r1_col;
			blur.red_out   = head.rgb[bbr_pkg::CH_RED];
			blur.green_out = head.rgb[bbr_pkg::CH_GREEN];
			blur.blue_out  = head.rgb[bbr_pkg::CH_BLUE];
		end else if (cur[bbr_pkg::RES_EOL]) begin
			blur.out_row   = head.meta.r1_row;
			blur.out_col   = head.meta.r2_col;
			blur.red_out   = '0;
			blur.green_out = '0;
			blur.blue_out  = '0;
		end else begin
			blur.out_row   = head.meta.r3_row;
			blur.out_col   = head.meta.r3_col;
			blur.red_out   = '0;
			blur.green_out = '0;
			blur.blue_out  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			done_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				done_q   <= '0;
			end else if (word_acc) begin
				done_q <= done_q | cur;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < (bbr_pkg::Q_AW+1)'(bbr_pkg::Q_DEPTH)))
		else $error("result queue overflow");
	a_head_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		blur_valid |-> rem != '0)
		else $error("queue head has no word left to send");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		word_acc && blur.last_of_run |=> done_q == '0)
		else $error("word mask not cleared after last word");
`endif

endmodule

// ===== src/box_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of an RGB frame with line stores in memory.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at up to one word per clock. Each pixel gives
// zero to three result words (row 0 none, interior one, last column and last
// row more); the result port moves one word per clock while blur_ready is
// high, so the input rate is one pixel per clock while each pixel yields at
// most one word and drops where it yields more. After reset the line store
// memory is cleared, one column per clock across all MAX_WIDTH columns, during
// which no pixel is taken; configuration writes are taken at any time. Width
// and height below 3 act as 3, above MAX_WIDTH / MAX_HEIGHT as that maximum.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bbr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bbr_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            pixel_valid,
	output logic                            pixel_ready,
	input  bbr_pkg::pix_in_t                pixel,
	output logic                            blur_valid,
	input  logic                            blur_ready,
	output bbr_pkg::pix_out_t               blur
);

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int CIW = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT + 1);
	localparam int RIW = $clog2(MAX_HEIGHT);
	localparam int SWW = (CW > bbr_pkg::CFG_W) ? CW : bbr_pkg::CFG_W;
	localparam int SWH = (RW > bbr_pkg::CFG_W) ? RW : bbr_pkg::CFG_W;

	function automatic logic [CW-1:0] clamp_w(input logic [bbr_pkg::CFG_W-1:0] v);
		logic [SWW-1:0] ve;
		ve = SWW'(v);
		if (ve < SWW'(bbr_pkg::MIN_SIZE)) begin
			return CW'(bbr_pkg::MIN_SIZE);
		end else if (ve > SWW'(MAX_WIDTH)) begin
			return CW'(MAX_WIDTH);
		end
		return CW'(ve);
	endfunction

	function automatic logic [RW-1:0] clamp_h(input logic [bbr_pkg::CFG_W-1:0] v);
		logic [SWH-1:0] ve;
		ve = SWH'(v);
		if (ve < SWH'(bbr_pkg::MIN_SIZE)) begin
			return RW'(bbr_pkg::MIN_SIZE);
		end else if (ve > SWH'(MAX_HEIGHT)) begin
			return RW'(MAX_HEIGHT);
		end
		return RW'(ve);
	endfunction

	logic [CW-1:0]  wid_q;
	logic [RW-1:0]  hgt_q;
	logic [CIW-1:0] col_q;
	logic [RIW-1:0] row_q;
	logic [bbr_pkg::Q_AW:0] total_q;

	logic           accept, busy, pop, push;
	logic [CW-1:0]  c_a, c_n;
	logic [RW-1:0]  r_a, r_n;
	logic [CIW-1:0] i_cur, col_next;
	logic [RIW-1:0] j_cur, row_next;
	bbr_pkg::meta_t meta_d;
	bbr_pkg::rgb_t  px_d;
	bbr_pkg::rgb_t  col_a, col_b;
	bbr_pkg::q_entry_t push_entry;

	logic           s1_valid;
	logic [CIW-1:0] idx_s1;
	bbr_pkg::rgb_t  px_s1;
	bbr_pkg::meta_t meta_s1;

	assign pixel_ready = !busy && (total_q < (bbr_pkg::Q_AW+1)'(bbr_pkg::Q_DEPTH));
	assign accept      = pixel_valid && pixel_ready;

	assign px_d[bbr_pkg::CH_RED]   = pixel.red_in;
	assign px_d[bbr_pkg::CH_GREEN] = pixel.green_in;
	assign px_d[bbr_pkg::CH_BLUE]  = pixel.blue_in;

	// position of this pixel and of the next one
	always_comb begin
		c_a = pixel.frame_start ? '0 : CW'(col_q);
		r_a = pixel.frame_start ? '0 : RW'(row_q);
		if (c_a >= wid_q) begin
			c_a = '0;
			r_a = r_a + 1'b1;
		end
		if (r_a >= hgt_q) begin
			r_a = '0;
		end
		i_cur = c_a[CIW-1:0];
		j_cur = r_a[RIW-1:0];

		c_n = CW'(i_cur) + 1'b1;
		r_n = RW'(j_cur);
		if (c_n >= wid_q) begin
			c_n = '0;
			r_n = RW'(j_cur) + 1'b1;
			if (r_n >= hgt_q) begin
				r_n = '0;
			end
		end
		col_next = c_n[CIW-1:0];
		row_next = r_n[RIW-1:0];
	end

	always_comb begin
		meta_d.has[bbr_pkg::RES_MAIN] = (j_cur != '0) && (i_cur != '0);
		meta_d.has[bbr_pkg::RES_EOL]  = (j_cur != '0) && (CW'(i_cur) == wid_q - 1'b1);
		meta_d.has[bbr_pkg::RES_EOF]  = (RW'(j_cur) == hgt_q - 1'b1);
		meta_d.interior = (j_cur != '0) && (j_cur != RIW'(1))
			&& (i_cur != '0) && (i_cur != CIW'(1));
		meta_d.r1_row = bbr_pkg::POS_W'(j_cur - 1'b1);
		meta_d.r1_col = bbr_pkg::POS_W'(i_cur - 1'b1);
		meta_d.r2_col = bbr_pkg::POS_W'(wid_q - 1'b1);
		meta_d.r3_row = bbr_pkg::POS_W'(hgt_q - 1'b1);
		meta_d.r3_col = bbr_pkg::POS_W'(i_cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q    <= clamp_w(bbr_pkg::CFG_W'(bbr_pkg::IMAGE_WIDTH_RST));
			hgt_q    <= clamp_h(bbr_pkg::CFG_W'(bbr_pkg::IMAGE_HEIGHT_RST));
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
			total_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					bbr_pkg::REG_IMAGE_WIDTH:  wid_q <= clamp_w(cfg_data);
					bbr_pkg::REG_IMAGE_HEIGHT: hgt_q <= clamp_h(cfg_data);
					default: ;
				endcase
			end
			if (accept) begin
				col_q <= col_next;
				row_q <= row_next;
			end
			s1_valid <= accept;
			case ({accept && (meta_d.has != '0), pop})
				2'b10:   total_q <= total_q + 1'b1;
				2'b01:   total_q <= total_q - 1'b1;
				default: total_q <= total_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= i_cur;
		px_s1   <= px_d;
		meta_s1 <= meta_d;
	end

	bbr_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CIW)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_idx (i_cur),
		.wr_en  (s1_valid),
		.wr_idx (idx_s1),
		.wr_px  (px_s1),
		.col_a  (col_a),
		.col_b  (col_b),
		.busy   (busy)
	);

	bbr_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.s1_meta    (meta_s1),
		.col_top    (col_b),
		.col_mid    (col_a),
		.col_bot    (px_s1),
		.push       (push),
		.push_entry (push_entry)
	);

	bbr_out_queue u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.blur_valid (blur_valid),
		.blur_ready (blur_ready),
		.blur       (blur),
		.pop        (pop)
	);

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= (bbr_pkg::Q_AW+1)'(bbr_pkg::Q_DEPTH))
		else $error("result credit count out of range");
	a_credit_covers_out: assert property (@(posedge clk) disable iff (!arst_n)
		blur_valid |-> total_q != '0)
		else $error("result word without reserved credit");
	a_idle_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s1_valid && !push)
		else $error("pixel in flight during clearing sweep");
`endif

endmodule
